// ----- sv/eds_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Edit distance scorer package
// Shared types and constants for the edit distance scorer cell chain.
// ----------------------------------------------------------------------------
package eds_pkg;

	localparam int unsigned CHAR_W    = 8;
	localparam int unsigned REG_W     = 64;
	localparam int unsigned QLEN_W    = 5;
	localparam int unsigned CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHARS_LOW  = 2'd0,
		REG_CHARS_HIGH = 2'd1,
		REG_LENGTH     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic              vld;
		logic              has_char;
		logic              last;
		logic [CHAR_W-1:0] ch;
	} eds_tok_t;

endpackage
`default_nettype wire

// ----- sv/edit_distance_scorer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Edit distance scorer
// Levenshtein distance of streamed candidate words to a configured query.
// ----------------------------------------------------------------------------
// The query is written through the configuration port while the block is idle:
// characters 0 to 7, characters 8 to 15 and the query length.
// Candidate words enter one character per input transfer; word_end marks the
// last transfer of a word, and an empty word is a single transfer with no_char
// and word_end set. Each word yields one output transfer with its distance.
// A row of QUERY_MAX+1 cells, one per column entry, passes every character
// one cell per cycle while the output does not stall, so one input transfer is
// taken every cycle unless out_ready holds the row; the distance is registered at the output after the last cell.
// The cell row is a single pipeline: while the output waits on out_ready, the
// row holds and in_ready is low.
// Reset clears the query registers and returns every column entry to its
// position, so the first word starts from a fresh column.
// ----------------------------------------------------------------------------
module edit_distance_scorer #(
	parameter int unsigned QUERY_MAX  = 16,
	parameter int unsigned DIST_WIDTH = 7
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [eds_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [eds_pkg::REG_W-1:0]      cfg_wdata,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [eds_pkg::CHAR_W-1:0]     candidate_char,
	input  wire logic                           no_char,
	input  wire logic                           word_end,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [DIST_WIDTH-1:0]          edit_distance
);

	localparam logic [eds_pkg::QLEN_W-1:0] QMAX_LEN = eds_pkg::QLEN_W'(QUERY_MAX);

	logic [eds_pkg::REG_W-1:0]  qlo_q;
	logic [eds_pkg::REG_W-1:0]  qhi_q;
	logic [eds_pkg::QLEN_W-1:0] qlen_q;
	logic [eds_pkg::QLEN_W-1:0] qlen_eff;
	logic [2*eds_pkg::REG_W-1:0] qchars;

	logic                  adv;
	logic                  out_valid_q;
	logic [DIST_WIDTH-1:0] dist_q;
	eds_pkg::eds_tok_t     tok_in;

	eds_pkg::eds_tok_t     tok [0:QUERY_MAX];
	logic [DIST_WIDTH-1:0] vnew [0:QUERY_MAX];
	logic [DIST_WIDTH-1:0] vold [0:QUERY_MAX];
	logic [DIST_WIDTH-1:0] vres [0:QUERY_MAX];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlo_q  <= '0;
			qhi_q  <= '0;
			qlen_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				eds_pkg::REG_CHARS_LOW:  qlo_q  <= cfg_wdata;
				eds_pkg::REG_CHARS_HIGH: qhi_q  <= cfg_wdata;
				eds_pkg::REG_LENGTH:     qlen_q <= cfg_wdata[eds_pkg::QLEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign qlen_eff = (qlen_q > QMAX_LEN) ? QMAX_LEN : qlen_q;
	assign qchars   = {qhi_q, qlo_q};

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	always_comb begin
		tok_in.vld      = in_valid && adv && (!no_char || word_end);
		tok_in.has_char = !no_char;
		tok_in.last     = word_end;
		tok_in.ch       = candidate_char;
	end

	eds_head #(
		.DIST_WIDTH(DIST_WIDTH)
	) u_head (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.sel     (qlen_eff == '0),
		.tok_in  (tok_in),
		.tok_out (tok[0]),
		.new_out (vnew[0]),
		.old_out (vold[0]),
		.res_out (vres[0])
	);

	for (genvar k = 1; k <= QUERY_MAX; k++) begin : g_cell
		eds_cell #(
			.POS        (k),
			.DIST_WIDTH (DIST_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.sel      (qlen_eff == eds_pkg::QLEN_W'(k)),
			.qchar    (qchars[eds_pkg::CHAR_W*(k-1) +: eds_pkg::CHAR_W]),
			.tok_in   (tok[k-1]),
			.left_new (vnew[k-1]),
			.left_old (vold[k-1]),
			.res_in   (vres[k-1]),
			.tok_out  (tok[k]),
			.new_out  (vnew[k]),
			.old_out  (vold[k]),
			.res_out  (vres[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= tok[QUERY_MAX].vld && tok[QUERY_MAX].last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dist_q <= vres[QUERY_MAX];
		end
	end

	assign out_valid     = out_valid_q;
	assign edit_distance = dist_q;

	// A new result only appears when a word end leaves the last cell.
	a_result_from_tail: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(tok[QUERY_MAX].vld && tok[QUERY_MAX].last))
		else $error("result without a word end at the tail of the row");

	// While the output stalls, the tail of the row holds its token.
	a_tail_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(tok[QUERY_MAX].vld) && $stable(vres[QUERY_MAX])))
		else $error("cell row moved while the output was stalled");

	// An accepted input with no character and no word end never enters the row.
	a_drop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && no_char && !word_end) |=> !tok[0].vld)
		else $error("empty item entered the cell row");

endmodule
`default_nettype wire

// ----- sv/eds_head.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Edit distance head cell
// Holds column entry zero, which counts the characters of the current word.
// ----------------------------------------------------------------------------
module eds_head #(
	parameter int unsigned DIST_WIDTH = 7
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  adv,
	input  wire logic                  sel,
	input  wire eds_pkg::eds_tok_t     tok_in,
	output eds_pkg::eds_tok_t          tok_out,
	output logic     [DIST_WIDTH-1:0]  new_out,
	output logic     [DIST_WIDTH-1:0]  old_out,
	output logic     [DIST_WIDTH-1:0]  res_out
);

	localparam logic [DIST_WIDTH-1:0] SAT = {DIST_WIDTH{1'b1}};

	logic [DIST_WIDTH-1:0] d_q;
	logic [DIST_WIDTH-1:0] nxt;

	always_comb begin
		if (tok_in.has_char && (d_q != SAT)) begin
			nxt = d_q + 1'b1;
		end else begin
			nxt = d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q     <= '0;
			tok_out <= '0;
		end else if (adv) begin
			tok_out <= tok_in;
			if (tok_in.vld) begin
				d_q <= tok_in.last ? '0 : nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			new_out <= nxt;
			old_out <= d_q;
			res_out <= sel ? nxt : '0;
		end
	end

endmodule
`default_nettype wire

// ----- sv/eds_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Edit distance query cell
// Holds one column entry and updates it from its left neighbor's entries.
// ----------------------------------------------------------------------------
module eds_cell #(
	parameter int unsigned POS        = 1,
	parameter int unsigned DIST_WIDTH = 7
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        adv,
	input  wire logic                        sel,
	input  wire logic [eds_pkg::CHAR_W-1:0]  qchar,
	input  wire eds_pkg::eds_tok_t           tok_in,
	input  wire logic [DIST_WIDTH-1:0]       left_new,
	input  wire logic [DIST_WIDTH-1:0]       left_old,
	input  wire logic [DIST_WIDTH-1:0]       res_in,
	output eds_pkg::eds_tok_t                tok_out,
	output logic      [DIST_WIDTH-1:0]       new_out,
	output logic      [DIST_WIDTH-1:0]       old_out,
	output logic      [DIST_WIDTH-1:0]       res_out
);

	localparam logic [DIST_WIDTH-1:0] SAT = {DIST_WIDTH{1'b1}};
	localparam logic [DIST_WIDTH:0]   POS_EXT = (DIST_WIDTH+1)'(POS);
	localparam logic [DIST_WIDTH-1:0] RST_VAL =
		(POS_EXT > {1'b0, SAT}) ? SAT : POS_EXT[DIST_WIDTH-1:0];

	logic [DIST_WIDTH-1:0] d_q;
	logic [DIST_WIDTH-1:0] up_inc;
	logic [DIST_WIDTH-1:0] left_inc;
	logic [DIST_WIDTH-1:0] diag;
	logic [DIST_WIDTH-1:0] best;
	logic [DIST_WIDTH-1:0] nxt;
	logic [DIST_WIDTH:0]   diag_sum;

	always_comb begin
		up_inc   = (d_q == SAT) ? SAT : d_q + 1'b1;
		left_inc = (left_new == SAT) ? SAT : left_new + 1'b1;
		diag_sum = {1'b0, left_old} + {{DIST_WIDTH{1'b0}}, (tok_in.ch != qchar)};
		diag     = diag_sum[DIST_WIDTH] ? SAT : diag_sum[DIST_WIDTH-1:0];
		best     = (up_inc < left_inc) ? up_inc : left_inc;
		if (diag < best) begin
			best = diag;
		end
		nxt = tok_in.has_char ? best : d_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q     <= RST_VAL;
			tok_out <= '0;
		end else if (adv) begin
			tok_out <= tok_in;
			if (tok_in.vld) begin
				d_q <= tok_in.last ? RST_VAL : nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			new_out <= nxt;
			old_out <= d_q;
			res_out <= sel ? nxt : res_in;
		end
	end

endmodule
`default_nettype wire
